/* src/rqr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqr_pkg
// Shared sizes, codes and control types for the ready queue block.
// ----------------------------------------------------------------------------
package rqr_pkg;

    localparam int DEPTH    = 16;
    localparam int ID_WIDTH = 8;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int POS_W    = $clog2(DEPTH);
    localparam int ACT_W    = 3;
    localparam int ST_W     = 2;

    // action codes; anything else is a no-op
    localparam logic [ACT_W-1:0] ACT_ENQUEUE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DEQUEUE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef logic [ID_WIDTH-1:0] t_id;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [POS_W-1:0]    t_pos;

    // controller -> datapath commands
    typedef struct packed {
        logic load_in;   // capture the incoming item
        logic execute;   // apply the action and load the result register
    } t_ctrl;

endpackage
`default_nettype wire

/* src/rqr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqr_ctrl
// Handshake controller: takes one item, executes it once the result
// register is free, and owns the output valid flag.
// ----------------------------------------------------------------------------
module rqr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output rqr_pkg::t_ctrl     o_ctrl
);
    import rqr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid;
        o_ctrl.load_in = 1'b0;
        o_ctrl.execute = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load_in = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_ctrl.execute = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

/* src/rqr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqr_dp
// Queue datapath: entry row with per-entry match and shift-up, occupancy
// counter, item capture registers and result registers.
// ----------------------------------------------------------------------------
module rqr_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rqr_pkg::t_ctrl            i_ctrl,
    input  wire logic [rqr_pkg::ACT_W-1:0] i_action,
    input  wire rqr_pkg::t_id              i_process_id,
    output rqr_pkg::t_id                   o_result_id,
    output logic [rqr_pkg::ST_W-1:0]       o_status,
    output rqr_pkg::t_cnt                  o_occupancy
);
    import rqr_pkg::*;

    // captured item
    logic [ACT_W-1:0] r_act;
    t_id              r_pid;

    // queue state; entry 0 is the head
    t_id  r_entries [DEPTH];
    t_id  n_entries [DEPTH];
    t_cnt r_count, n_count;

    // result registers
    t_id              r_rid, n_rid;
    logic [ST_W-1:0]  r_st,  n_st;

    logic [DEPTH-1:0] match;
    logic             found;
    t_pos             hit_pos;
    logic             do_shift;
    t_pos             shift_pos;
    logic             empty;
    logic             full;

    assign empty = (r_count == '0);
    assign full  = (r_count == t_cnt'(DEPTH));

    // per-entry compare, live entries only
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            match[k] = (t_cnt'(k) < r_count) && (r_entries[k] == r_pid);
        end
    end

    // first match from the head
    always_comb begin
        found   = 1'b0;
        hit_pos = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (match[k]) begin
                found   = 1'b1;
                hit_pos = t_pos'(k);
            end
        end
    end

    always_comb begin
        n_rid     = '0;
        n_st      = ST_OK;
        n_count   = r_count;
        do_shift  = 1'b0;
        shift_pos = '0;
        for (int k = 0; k < DEPTH; k++) begin
            n_entries[k] = r_entries[k];
        end

        case (r_act)
            ACT_ENQUEUE: begin
                if (full) begin
                    n_st = ST_FULL;
                end else begin
                    n_entries[r_count[POS_W-1:0]] = r_pid;
                    n_count = r_count + t_cnt'(1);
                    n_rid   = r_pid;
                end
            end
            ACT_DEQUEUE: begin
                if (empty) begin
                    n_st = ST_EMPTY;
                end else begin
                    n_rid     = r_entries[0];
                    do_shift  = 1'b1;
                    shift_pos = '0;
                    n_count   = r_count - t_cnt'(1);
                end
            end
            ACT_PEEK: begin
                if (empty) begin
                    n_st = ST_EMPTY;
                end else begin
                    n_rid = r_entries[0];
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            ACT_REMOVE: begin
                if (empty) begin
                    n_st = ST_EMPTY;
                end else if (!found) begin
                    n_st = ST_NOT_FOUND;
                end else begin
                    n_rid     = r_pid;
                    do_shift  = 1'b1;
                    shift_pos = hit_pos;
                    n_count   = r_count - t_cnt'(1);
                end
            end
            default: begin
            end
        endcase

        // close the gap: everything behind the removed slot moves up one
        if (do_shift) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                if (t_pos'(k) >= shift_pos) begin
                    n_entries[k] = r_entries[k + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_act <= i_action;
            r_pid <= i_process_id;
        end
        if (i_ctrl.execute) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_entries[k] <= n_entries[k];
            end
            r_rid <= n_rid;
            r_st  <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.execute) begin
            r_count <= n_count;
        end
    end

    assign o_result_id = r_rid;
    assign o_status    = r_st;
    assign o_occupancy = r_count;

endmodule
`default_nettype wire

/* src/ready_queue_with_removal.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ready_queue_with_removal
// Bounded FIFO of process identifiers with enqueue, dequeue, peek, clear
// and remove-first-match.
// ----------------------------------------------------------------------------
// Each accepted item is one action and yields exactly one result item with
// the identifier involved (zero when none), a status (ok, empty, full, not
// found) and the occupancy after the action. Each item is first captured and
// then executed: all entries are compared against the identifier in
// parallel, the first match from the head is chosen and the entries behind
// it shift up one place, all in the entry register row.
// The result sits in an output register; the block stalls input only while
// an item is in flight, and the execute cycle waits for that register to be
// free, so a full result register holds back one further item at most.
// Duplicates are allowed; an enqueue into a full queue is dropped and
// reported as full. Codes five to seven do nothing and report ok.
// ----------------------------------------------------------------------------
module ready_queue_with_removal (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_action,
    input  wire logic [7:0] i_process_id,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_result_id,
    output logic [1:0]      o_status,
    output logic [4:0]      o_occupancy
);
    import rqr_pkg::*;

    t_ctrl ctrl;   // controller commands to the datapath

    rqr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctrl      (ctrl)
    );

    rqr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_action     (i_action),
        .i_process_id (i_process_id),
        .o_result_id  (o_result_id),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

endmodule
`default_nettype wire
